@@ hw/rtl/utf8_validate_sanitize_stream_core_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-8 stream core assertion macros
// Shared concurrent assertion forms for the decoder, queue and encoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_SANITIZE_STREAM_CORE_DEFINES_SVH
`define UTF8_VALIDATE_SANITIZE_STREAM_CORE_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define UTF8VS_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define UTF8VS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UTF8VS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/utf8vs_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream core package
// Beat types, register codes, queue entry and UTF-8 encode helpers.
// ----------------------------------------------------------------------------
package utf8vs_pkg;

    localparam int COUNT_BITS = 32;
    localparam int CP_BITS    = 21;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CP_BITS-1:0]    cp_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_VALIDATE_ONLY = 2'd0;
    localparam logic [1:0] CFG_IDX_DROP_MARK     = 2'd1;
    localparam logic [1:0] CFG_IDX_REPORT_MARK   = 2'd2;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;

    localparam cp_t REPL_CP     = 21'h00FFFD;
    localparam cp_t BOM_CP      = 21'h00FEFF;
    localparam cp_t CP_MAX      = 21'h10FFFF;
    localparam cp_t SURR_LO     = 21'h00D800;
    localparam cp_t SURR_HI     = 21'h00DFFF;
    localparam cp_t MIN_TWO     = 21'h000080;
    localparam cp_t MIN_THREE   = 21'h000800;
    localparam cp_t MIN_FOUR    = 21'h010000;
    localparam cp_t ONE_MAX     = 21'h00007F;
    localparam cp_t TWO_MAX     = 21'h0007FF;
    localparam cp_t THREE_MAX   = 21'h00FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_present;
        logic        out_last;
        logic [31:0] codepoint_total;
        logic [31:0] invalid_total;
        logic        bom_seen;
    } out_beat_t;

    typedef struct packed {
        logic validate_only;
        logic drop_mark;
        logic report_mark;
    } cfg_t;

    // One queue entry: up to two codepoints to encode, with counter
    // snapshots after the first and after the last of them.
    typedef struct packed {
        logic [1:0] ncp;
        cp_t        cp0;
        cp_t        cp1;
        count_t     cnt0;
        count_t     inv0;
        count_t     cnt1;
        count_t     inv1;
        logic       bom;
        logic       last;
    } entry_t;

    function automatic count_t sat_add(input count_t v, input logic [1:0] k);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, v} + (COUNT_BITS + 1)'(k);
        return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    endfunction

    function automatic logic [2:0] cp_len(input cp_t cp);
        logic [2:0] len;
        priority if (cp <= ONE_MAX) len = LEN_ONE;
        else if (cp <= TWO_MAX)     len = LEN_TWO;
        else if (cp <= THREE_MAX)   len = LEN_THREE;
        else                        len = LEN_FOUR;
        return len;
    endfunction

    function automatic logic [7:0] cp_byte(input cp_t cp, input logic [1:0] idx);
        logic [2:0] len;
        logic [7:0] b;
        len = cp_len(cp);
        b   = 8'h00;
        unique case (len)
            LEN_ONE: b = {1'b0, cp[6:0]};
            LEN_TWO: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            LEN_THREE: begin
                unique case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0: b = {5'b11110, cp[20:18]};
                    2'd1: b = {2'b10, cp[17:12]};
                    2'd2: b = {2'b10, cp[11:6]};
                    2'd3: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/utf8_validate_sanitize_stream_core.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and sanitize stream core
// Decodes a byte stream, replaces malformed sequences with U+FFFD, and
// either re-encodes the result or only counts and reports per stream.
// ----------------------------------------------------------------------------
//  channel   ports                          beat
//  -------   -----------------------------  -----------------------------------
//  input     s_valid s_ready s_beat         one raw byte, last flag
//  result    m_valid m_ready m_beat         one output byte or a summary
//  config    cfg_valid cfg_ready cfg_index  register index and one data bit
//            cfg_data
//
//  The front end takes one byte per cycle while the queue has room; the
//  encoder back end sends one output byte per cycle while the result
//  channel is ready, and one input byte yields zero to six output bytes.
//  Decoded results are registered in the queue and then in the output register.
//  Result stalls are absorbed by a four-entry queue before input stalls.
//  Reset is synchronous, active low; it restores register defaults and
//  starts a new stream. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module utf8_validate_sanitize_stream_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utf8vs_pkg::in_beat_t  s_beat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8vs_pkg::out_beat_t m_beat,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic                  cfg_data
);

    utf8vs_pkg::cfg_t   cfg_reg, cfg_next;
    utf8vs_pkg::entry_t push_entry;
    utf8vs_pkg::entry_t head;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                utf8vs_pkg::CFG_IDX_VALIDATE_ONLY: cfg_next.validate_only = cfg_data;
                utf8vs_pkg::CFG_IDX_DROP_MARK:     cfg_next.drop_mark     = cfg_data;
                utf8vs_pkg::CFG_IDX_REPORT_MARK:   cfg_next.report_mark   = cfg_data;
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.validate_only <= 1'b0;
            cfg_reg.drop_mark     <= 1'b0;
            cfg_reg.report_mark   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    utf8vs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .cfg        (cfg_reg),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    utf8vs_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    utf8vs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_beat     (m_beat)
    );

endmodule

@@ hw/rtl/utf8vs_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decode front end
// Accepts one byte per cycle while the queue has room, tracks the open sequence,
// resolves the codepoints each byte completes and queues them with counter snapshots.
// ----------------------------------------------------------------------------
`include "utf8_validate_sanitize_stream_core_defines.svh"

module utf8vs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  utf8vs_pkg::in_beat_t s_beat,
    input  utf8vs_pkg::cfg_t    cfg,
    input  logic                fifo_full,
    output logic                push,
    output utf8vs_pkg::entry_t  push_entry
);

    typedef struct packed {
        logic            present;
        logic            bad;
        utf8vs_pkg::cp_t cp;
    } evt_t;

    utf8vs_pkg::cp_t    partial_reg, partial_next;
    logic [2:0]         exp_len_reg, exp_len_next;
    logic [2:0]         taken_reg, taken_next;
    logic               at_start_reg, at_start_next;
    utf8vs_pkg::count_t cnt_reg, cnt_next;
    utf8vs_pkg::count_t inv_reg, inv_next;
    logic               bom_reg, bom_next;

    logic [7:0]         b;
    logic               accept;
    logic               lead_run;
    logic               seq_ok;
    utf8vs_pkg::cp_t    part_acc;
    utf8vs_pkg::cp_t    min_val;
    logic [2:0]         taken_inc;
    logic [2:0]         open_len;
    utf8vs_pkg::cp_t    open_part;
    logic [2:0]         open_taken;
    evt_t               ev_a, ev_b, ev_c;
    evt_t               slot0, slot1, keep0, keep1;
    logic               bom_hit, drop0;
    logic [1:0]         n_keep, n_bad;
    utf8vs_pkg::count_t cnt0, cnt1, inv0, inv1;

    assign b       = s_beat.in_byte;
    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        part_acc  = {partial_reg[utf8vs_pkg::CP_BITS-7:0], b[5:0]};
        taken_inc = taken_reg + 3'd1;
        unique case (exp_len_reg)
            utf8vs_pkg::LEN_TWO:   min_val = utf8vs_pkg::MIN_TWO;
            utf8vs_pkg::LEN_THREE: min_val = utf8vs_pkg::MIN_THREE;
            default:               min_val = utf8vs_pkg::MIN_FOUR;
        endcase
        seq_ok = (part_acc >= min_val) && (part_acc <= utf8vs_pkg::CP_MAX) &&
                 !((part_acc >= utf8vs_pkg::SURR_LO) && (part_acc <= utf8vs_pkg::SURR_HI));

        ev_a       = '0;
        ev_b       = '0;
        ev_c       = '0;
        lead_run   = 1'b0;
        open_len   = exp_len_reg;
        open_part  = partial_reg;
        open_taken = taken_reg;

        priority if (exp_len_reg == utf8vs_pkg::LEN_NONE) begin
            lead_run = 1'b1;
        end else if (b[7:6] == 2'b10) begin
            if (taken_inc >= exp_len_reg) begin
                ev_a       = {1'b1, !seq_ok, seq_ok ? part_acc : utf8vs_pkg::REPL_CP};
                open_len   = utf8vs_pkg::LEN_NONE;
                open_part  = '0;
                open_taken = 3'd0;
            end else begin
                open_part  = part_acc;
                open_taken = taken_inc;
            end
        end else begin
            // broken sequence: replace it, then treat this byte as a lead
            ev_a     = {1'b1, 1'b1, utf8vs_pkg::REPL_CP};
            lead_run = 1'b1;
        end

        if (lead_run) begin
            open_len   = utf8vs_pkg::LEN_NONE;
            open_part  = '0;
            open_taken = 3'd0;
            priority if (b[7] == 1'b0) begin
                ev_b = {1'b1, 1'b0, utf8vs_pkg::cp_t'(b)};
            end else if (b >= utf8vs_pkg::LEAD2_MIN && b <= utf8vs_pkg::LEAD2_MAX) begin
                open_len   = utf8vs_pkg::LEN_TWO;
                open_part  = utf8vs_pkg::cp_t'(b[4:0]);
                open_taken = 3'd1;
            end else if (b >= utf8vs_pkg::LEAD3_MIN && b <= utf8vs_pkg::LEAD3_MAX) begin
                open_len   = utf8vs_pkg::LEN_THREE;
                open_part  = utf8vs_pkg::cp_t'(b[3:0]);
                open_taken = 3'd1;
            end else if (b >= utf8vs_pkg::LEAD4_MIN && b <= utf8vs_pkg::LEAD4_MAX) begin
                open_len   = utf8vs_pkg::LEN_FOUR;
                open_part  = utf8vs_pkg::cp_t'(b[2:0]);
                open_taken = 3'd1;
            end else begin
                ev_b = {1'b1, 1'b1, utf8vs_pkg::REPL_CP};
            end
        end

        // sequence cut short by end of stream
        if (s_beat.in_last && open_len != utf8vs_pkg::LEN_NONE) begin
            ev_c = {1'b1, 1'b1, utf8vs_pkg::REPL_CP};
        end

        slot0 = ev_a.present ? ev_a : (ev_b.present ? ev_b : ev_c);
        if (ev_a.present) begin
            slot1 = ev_b.present ? ev_b : ev_c;
        end else begin
            slot1 = ev_b.present ? ev_c : '0;
        end

        bom_hit = at_start_reg && slot0.present && !slot0.bad &&
                  (slot0.cp == utf8vs_pkg::BOM_CP);
        drop0   = bom_hit && !cfg.validate_only && cfg.drop_mark;
        keep0   = drop0 ? slot1 : slot0;
        keep1   = drop0 ? '0 : slot1;

        n_keep = {1'b0, keep0.present} + {1'b0, keep1.present};
        n_bad  = {1'b0, keep0.present & keep0.bad} + {1'b0, keep1.present & keep1.bad};
        cnt0   = utf8vs_pkg::sat_add(cnt_reg, 2'd1);
        cnt1   = utf8vs_pkg::sat_add(cnt_reg, n_keep);
        inv0   = utf8vs_pkg::sat_add(inv_reg, {1'b0, keep0.present & keep0.bad});
        inv1   = utf8vs_pkg::sat_add(inv_reg, n_bad);

        bom_next = bom_reg | (bom_hit & (cfg.validate_only ? cfg.report_mark : 1'b1));

        push_entry.ncp  = cfg.validate_only ? 2'd0 : n_keep;
        push_entry.cp0  = keep0.cp;
        push_entry.cp1  = keep1.cp;
        push_entry.cnt0 = cnt0;
        push_entry.inv0 = inv0;
        push_entry.cnt1 = cnt1;
        push_entry.inv1 = inv1;
        push_entry.bom  = bom_next;
        push_entry.last = s_beat.in_last;

        push = accept && (cfg.validate_only ? s_beat.in_last
                                            : (n_keep != 2'd0 || s_beat.in_last));

        partial_next  = partial_reg;
        exp_len_next  = exp_len_reg;
        taken_next    = taken_reg;
        at_start_next = at_start_reg;
        cnt_next      = cnt_reg;
        inv_next      = inv_reg;
        if (accept) begin
            if (s_beat.in_last) begin
                // end of stream: return to a fresh stream
                partial_next  = '0;
                exp_len_next  = utf8vs_pkg::LEN_NONE;
                taken_next    = 3'd0;
                at_start_next = 1'b1;
                cnt_next      = '0;
                inv_next      = '0;
            end else begin
                partial_next  = open_part;
                exp_len_next  = open_len;
                taken_next    = open_taken;
                at_start_next = at_start_reg & !slot0.present;
                cnt_next      = cnt1;
                inv_next      = inv1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg  <= '0;
            exp_len_reg  <= utf8vs_pkg::LEN_NONE;
            taken_reg    <= 3'd0;
            at_start_reg <= 1'b1;
            cnt_reg      <= '0;
            inv_reg      <= '0;
            bom_reg      <= 1'b0;
        end else begin
            partial_reg  <= partial_next;
            exp_len_reg  <= exp_len_next;
            taken_reg    <= taken_next;
            at_start_reg <= at_start_next;
            cnt_reg      <= cnt_next;
            inv_reg      <= inv_next;
            if (accept) begin
                bom_reg <= s_beat.in_last ? 1'b0 : bom_next;
            end
        end
    end

    `UTF8VS_ASSERT_NEXT(a_last_restarts, aclk, aresetn, accept && s_beat.in_last, at_start_reg && exp_len_reg == utf8vs_pkg::LEN_NONE, "stream state not cleared after last beat")
    `UTF8VS_ASSERT_IMPLIES(a_open_progress, aclk, aresetn, exp_len_reg != utf8vs_pkg::LEN_NONE, taken_reg != 3'd0 && taken_reg < exp_len_reg, "open sequence byte count out of range")

endmodule

@@ hw/rtl/utf8vs_fifo.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decode queue
// Short register queue of decoded entries between front and back ends.
// ----------------------------------------------------------------------------
`include "utf8_validate_sanitize_stream_core_defines.svh"

module utf8vs_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  utf8vs_pkg::entry_t push_entry,
    input  logic               pop,
    output utf8vs_pkg::entry_t head,
    output logic               full,
    output logic               empty
);

    utf8vs_pkg::entry_t                  mem_reg [utf8vs_pkg::FIFO_DEPTH];
    logic [utf8vs_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [utf8vs_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [utf8vs_pkg::FIFO_CW-1:0]      count_reg, count_next;

    localparam logic [utf8vs_pkg::FIFO_AW-1:0] PTR_LAST =
        utf8vs_pkg::FIFO_AW'(utf8vs_pkg::FIFO_DEPTH - 1);
    localparam logic [utf8vs_pkg::FIFO_CW-1:0] COUNT_FULL =
        utf8vs_pkg::FIFO_CW'(utf8vs_pkg::FIFO_DEPTH);

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == COUNT_FULL);
    assign empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `UTF8VS_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `UTF8VS_ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, !empty, "pop from empty queue")

endmodule

@@ hw/rtl/utf8vs_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 encode back end
// Serializes each queued entry into output beats, one byte per beat or a
// single summary beat, and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "utf8_validate_sanitize_stream_core_defines.svh"

module utf8vs_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  utf8vs_pkg::entry_t    head,
    input  logic                  fifo_empty,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8vs_pkg::out_beat_t m_beat
);

    logic                  m_valid_reg, m_valid_next;
    utf8vs_pkg::out_beat_t beat_reg, beat_next;
    logic                  sel_reg, sel_next;
    logic [1:0]            pos_reg, pos_next;

    utf8vs_pkg::cp_t cur_cp;
    logic [2:0]      cur_len;
    logic            summary;
    logic            cp_done;
    logic            entry_done;
    logic            load;
    logic            use_final;

    assign m_valid = m_valid_reg;
    assign m_beat  = beat_reg;

    always_comb begin
        cur_cp     = sel_reg ? head.cp1 : head.cp0;
        cur_len    = utf8vs_pkg::cp_len(cur_cp);
        summary    = (head.ncp == 2'd0);
        cp_done    = ({1'b0, pos_reg} + 3'd1) == cur_len;
        entry_done = summary || (cp_done && (sel_reg || head.ncp == 2'd1));
        load       = !fifo_empty && (!m_valid_reg || m_ready);
        pop        = load && entry_done;
        use_final  = summary || sel_reg;

        beat_next.out_byte        = summary ? 8'h00 : utf8vs_pkg::cp_byte(cur_cp, pos_reg);
        beat_next.byte_present    = !summary;
        beat_next.out_last        = head.last && entry_done;
        beat_next.codepoint_total = 32'(use_final ? head.cnt1 : head.cnt0);
        beat_next.invalid_total   = 32'(use_final ? head.inv1 : head.inv0);
        beat_next.bom_seen        = head.bom;

        sel_next = sel_reg;
        pos_next = pos_reg;
        if (load) begin
            priority if (entry_done) begin
                sel_next = 1'b0;
                pos_next = 2'd0;
            end else if (cp_done) begin
                // advance to the second codepoint of the entry
                sel_next = 1'b1;
                pos_next = 2'd0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end

        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
            pos_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat_next;
        end
    end

    `UTF8VS_ASSERT_IMPLIES(a_partial_entry_held, aclk, aresetn, sel_reg || pos_reg != 2'd0, !fifo_empty, "entry left queue before all its bytes were sent")

endmodule

@@ bench/utf8_validate_sanitize_stream_core_tb.sv @@
// ----------------------------------------------------------------------------
// UTF-8 validate and sanitize stream core testbench
// Drives byte streams through the core under several register settings,
// predicts every result beat in a scoreboard and checks them in order.
// Directed streams cover the mark, replacement cases and end-of-stream cuts;
// random streams mix legal text with overlong, surrogate and broken input.
// ----------------------------------------------------------------------------
import utf8vs_pkg::*;

// One byte of the UTF-8 form of cp when written with len bytes.
function automatic logic [7:0] utf8_unit(input cp_t cp, input int len, input int idx);
    case (len)
        1: return {1'b0, cp[6:0]};
        2: return (idx == 0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        3: begin
            case (idx)
                0:       return {4'b1110, cp[15:12]};
                1:       return {2'b10, cp[11:6]};
                default: return {2'b10, cp[5:0]};
            endcase
        end
        default: begin
            case (idx)
                0:       return {5'b11110, cp[20:18]};
                1:       return {2'b10, cp[17:12]};
                2:       return {2'b10, cp[11:6]};
                default: return {2'b10, cp[5:0]};
            endcase
        end
    endcase
endfunction

class utf8_stream_tracker;
    out_beat_t  predicted_beats[$];
    int         errors = 0;
    int         beats_checked = 0;
    bit         validate_only = 1'b0;
    bit         drop_mark = 1'b0;
    bit         report_mark = 1'b1;
    cp_t        partial;
    logic [2:0] want_len;
    logic [2:0] got_len;
    bit         at_start;
    bit         bom;
    count_t     cp_count;
    count_t     bad_count;
    int         step_base;

    function new();
        clear_stream();
    endfunction

    function void set_reg(input logic [1:0] idx, input logic val);
        case (idx)
            CFG_IDX_VALIDATE_ONLY: validate_only = val;
            CFG_IDX_DROP_MARK:     drop_mark = val;
            CFG_IDX_REPORT_MARK:   report_mark = val;
            default: ;
        endcase
    endfunction

    function void end_seq();
        want_len = LEN_NONE;
        got_len  = 3'd0;
        partial  = '0;
    endfunction

    function void clear_stream();
        end_seq();
        at_start  = 1'b1;
        cp_count  = '0;
        bad_count = '0;
        bom       = 1'b0;
    endfunction

    function count_t bump(input count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function void push(input logic [7:0] b, input logic present);
        out_beat_t r;
        // at most six beats per input byte
        if (predicted_beats.size() - step_base >= 6)
            return;
        r.out_byte        = b;
        r.byte_present    = present;
        r.out_last        = 1'b0;
        r.codepoint_total = cp_count;
        r.invalid_total   = bad_count;
        r.bom_seen        = bom;
        predicted_beats.insert(predicted_beats.size(), r);
    endfunction

    function void emit_cp(input cp_t cp, input bit ok);
        bit first;
        int n;
        first    = at_start;
        at_start = 1'b0;
        if (!ok)
            cp = REPL_CP;
        if (first && ok && cp == BOM_CP) begin
            if (validate_only) begin
                if (report_mark)
                    bom = 1'b1;
            end else begin
                bom = 1'b1;
                if (drop_mark)
                    return;
            end
        end
        cp_count = bump(cp_count);
        if (!ok)
            bad_count = bump(bad_count);
        if (validate_only)
            return;
        n = (cp <= ONE_MAX) ? 1 : (cp <= TWO_MAX) ? 2 : (cp <= THREE_MAX) ? 3 : 4;
        for (int i = 0; i < n; i++)
            push(utf8_unit(cp, n, i), 1'b1);
    endfunction

    function void start_seq(input logic [7:0] b);
        if (b <= 8'h7F) begin
            emit_cp({13'd0, b}, 1'b1);
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            want_len = LEN_TWO;
            partial  = {16'd0, b[4:0]};
            got_len  = 3'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            want_len = LEN_THREE;
            partial  = {17'd0, b[3:0]};
            got_len  = 3'd1;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            want_len = LEN_FOUR;
            partial  = {18'd0, b[2:0]};
            got_len  = 3'd1;
        end else begin
            emit_cp('0, 1'b0);
        end
    endfunction

    function void note_byte(input in_beat_t beat);
        logic [7:0] b;
        cp_t        v;
        cp_t        floor_cp;
        bit         ok;
        out_beat_t  tail;
        b = beat.in_byte;
        step_base = predicted_beats.size();
        if (want_len == LEN_NONE) begin
            start_seq(b);
        end else if (b[7:6] == 2'b10) begin
            partial = {partial[14:0], b[5:0]};
            got_len = got_len + 3'd1;
            if (got_len >= want_len) begin
                v = partial;
                case (want_len)
                    LEN_TWO:   floor_cp = MIN_TWO;
                    LEN_THREE: floor_cp = MIN_THREE;
                    default:   floor_cp = MIN_FOUR;
                endcase
                ok = v >= floor_cp && v <= CP_MAX && !(v >= SURR_LO && v <= SURR_HI);
                end_seq();
                emit_cp(v, ok);
            end
        end else begin
            // broken sequence: replace it, then retry the byte as a lead
            end_seq();
            emit_cp('0, 1'b0);
            start_seq(b);
        end
        if (beat.in_last) begin
            if (want_len != LEN_NONE) begin
                end_seq();
                emit_cp('0, 1'b0);
            end
            if (predicted_beats.size() == step_base)
                push(8'h00, 1'b0);
            tail = predicted_beats[predicted_beats.size() - 1];
            tail.out_last = 1'b1;
            predicted_beats[predicted_beats.size() - 1] = tail;
            clear_stream();
        end
    endfunction

    function string show(input out_beat_t r);
        return $sformatf("byte %02h present %0b last %0b codepoints %0d invalid %0d bom %0b",
                         r.out_byte, r.byte_present, r.out_last, r.codepoint_total,
                         r.invalid_total, r.bom_seen);
    endfunction

    function void check_beat(input out_beat_t got);
        out_beat_t want;
        beats_checked++;
        if (predicted_beats.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat: %s", show(got));
            return;
        end
        want = predicted_beats.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch on result beat %0d", beats_checked);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
    endfunction
endclass

module utf8_validate_sanitize_stream_core_tb;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_beat_t   s_beat = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_beat;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_IDX_VALIDATE_ONLY;
    logic       cfg_data = 1'b0;

    utf8_stream_tracker sb = new();

    logic [7:0] stream_bytes[$];
    bit         idle_on = 1'b1;
    int         ready_hold = 0;
    int         bytes_sent = 0;
    int         streams_sent = 0;
    int         settings_used = 0;

    utf8_validate_sanitize_stream_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // result side: stall in random bursts while idle_on is set
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_beat);
            if (m_valid && m_ready)
                sb.check_beat(m_beat);
        end
    end

    function automatic cp_t legal_cp(input int len);
        cp_t lo;
        cp_t hi;
        cp_t cp;
        case (len)
            1:       begin lo = '0;        hi = ONE_MAX;   end
            2:       begin lo = MIN_TWO;   hi = TWO_MAX;   end
            3:       begin lo = MIN_THREE; hi = THREE_MAX; end
            default: begin lo = MIN_FOUR;  hi = CP_MAX;    end
        endcase
        case ($urandom_range(0, 3))
            0:       cp = lo;
            1:       cp = hi;
            default: cp = cp_t'($urandom_range(lo, hi));
        endcase
        // move off the surrogate block
        if (cp >= SURR_LO && cp <= SURR_HI)
            cp = cp ^ 21'h002000;
        return cp;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat  <= {b, l};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_queued(input int pause_at);
        for (int i = 0; i < stream_bytes.size(); i++) begin
            if (i == pause_at) begin
                // hold off until the core has delivered everything so far
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.predicted_beats.size() != 0) @(posedge aclk);
            end
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        streams_sent++;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (sb.predicted_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_config(input logic v, input logic s, input logic d);
        logic [1:0] idx;
        logic       val;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0:       begin idx = CFG_IDX_VALIDATE_ONLY; val = v; end
                1:       begin idx = CFG_IDX_DROP_MARK;     val = s; end
                default: begin idx = CFG_IDX_REPORT_MARK;   val = d; end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(idx, val);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic v, input logic s, input logic d, input bit quiet);
        int  phase_bytes;
        int  phase_streams;
        int  target;
        int  kind;
        int  len;
        int  keep;
        cp_t cp;
        idle_on = !quiet;
        apply_config(v, s, d);
        phase_bytes   = 0;
        phase_streams = 0;
        // validate mode answers once per stream, so use many short streams
        while (v ? (phase_streams < 10) : (phase_bytes < 12)) begin
            target = $urandom_range(1, v ? 4 : 12);
            stream_bytes.delete();
            if ($urandom_range(0, 3) == 0) begin
                stream_bytes.insert(stream_bytes.size(), 8'hEF);
                stream_bytes.insert(stream_bytes.size(), 8'hBB);
                stream_bytes.insert(stream_bytes.size(), 8'hBF);
            end
            while (stream_bytes.size() < target) begin
                kind = $urandom_range(0, 99);
                len  = $urandom_range(1, 4);
                keep = 0;
                if (kind < 15) begin
                    len = 1;
                    cp  = cp_t'($urandom_range(0, 127));
                end else if (kind < 50) begin
                    cp = legal_cp(len);
                end else if (kind < 60) begin
                    // overlong form
                    len = $urandom_range(2, 4);
                    cp  = cp_t'($urandom_range(0, (len == 2) ? 'h7F :
                                                  (len == 3) ? 'h7FF : 'hFFFF));
                end else if (kind < 68) begin
                    len = 3;
                    cp  = cp_t'($urandom_range(SURR_LO, SURR_HI));
                end else if (kind < 74) begin
                    len = 4;
                    cp  = cp_t'($urandom_range(21'h110000, 21'h1FFFFF));
                end else if (kind < 86) begin
                    // sequence cut short, next token breaks it
                    len  = $urandom_range(2, 4);
                    cp   = legal_cp(len);
                    keep = $urandom_range(1, len - 1);
                end else begin
                    len = 0;
                    stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
                end
                for (int i = 0; i < len; i++)
                    if (keep == 0 || i < keep)
                        stream_bytes.insert(stream_bytes.size(), utf8_unit(cp, len, i));
            end
            while (stream_bytes.size() > target) void'(stream_bytes.pop_back());
            send_queued(-1);
            phase_bytes += stream_bytes.size();
            phase_streams++;
        end
        s_valid <= 1'b0;
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sanitize: mark kept, extremes, bad leads, breaks, out of range,
        // surrogate, overlong, and a sequence cut by the end of the stream
        apply_config(1'b0, 1'b0, 1'b1);
        stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'hFF, 8'hC2, 8'h41,
                         8'hF4, 8'h90, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
                         8'hE0, 8'h80, 8'h80, 8'hE2};
        send_queued(6);
        s_valid <= 1'b0;
        drain();

        // stream made only of a stripped mark
        apply_config(1'b0, 1'b1, 1'b1);
        stream_bytes = '{8'hEF, 8'hBB, 8'hBF};
        send_queued(-1);
        s_valid <= 1'b0;
        drain();

        // validate mode reporting the mark
        apply_config(1'b1, 1'b1, 1'b1);
        stream_bytes = '{8'hEF, 8'hBB, 8'hBF};
        send_queued(-1);
        s_valid <= 1'b0;
        drain();

        run_phase(1'b0, 1'b1, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 1'b1, 1'b0);
        run_phase(1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 1'b1, 1'b1);

        $display("covered %0d bytes in %0d streams under %0d register settings",
                 bytes_sent, streams_sent, settings_used);
        $display("checked %0d result beats, %0d failures", sb.beats_checked, sb.errors);
        if (sb.errors == 0 && sb.predicted_beats.size() == 0) begin
            $display("[utf8_validate_sanitize_stream_core] OK");
        end else begin
            $display("[utf8_validate_sanitize_stream_core] ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d result beats still expected", sb.predicted_beats.size());
        $display("[utf8_validate_sanitize_stream_core] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/utf8vs_pkg.sv
hw/rtl/utf8vs_front.sv
hw/rtl/utf8vs_fifo.sv
hw/rtl/utf8vs_back.sv
hw/rtl/utf8_validate_sanitize_stream_core.sv
bench/utf8_validate_sanitize_stream_core_tb.sv
